@@ design/gaussian_blur_5x5_separable_core_macros.svh @@
// assertion macros for the separable 5x5 blur core
// used by the top level; expects clk and arst_n in scope
`ifndef GAUSSIAN_BLUR_5X5_SEPARABLE_CORE_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_SEPARABLE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define GB5S_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define GB5S_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GB5S_ASSERT_IMPL(lbl, ante, cons, msg)
`define GB5S_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/gb5s_pkg.sv @@
// shared constants, beat types and multiply-accumulate command for the blur core
// no dependencies
`timescale 1ns / 1ps
package gb5s_pkg;
	localparam int MAX_WIDTH     = 2048;
	localparam int TAP_FRAC_BITS = 16;
	localparam int PIX_W   = 8;
	localparam int COL_W   = 11;
	localparam int ROW_W   = 12;
	localparam int TAP_W   = 16;
	localparam int HSUM_W  = 27;
	localparam int PROD_W  = TAP_W + HSUM_W;
	localparam int ACC_W   = PROD_W + 3;
	localparam int LINES   = 4;
	localparam int RAM_DEPTH = LINES * MAX_WIDTH;
	localparam int ADDR_W  = $clog2(RAM_DEPTH);
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_TAP_M2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_TAP_M1 = 3'd3;
	localparam logic [IDX_W-1:0] REG_TAP_C  = 3'd4;
	localparam logic [IDX_W-1:0] REG_TAP_P1 = 3'd5;
	localparam logic [IDX_W-1:0] REG_TAP_P2 = 3'd6;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [PIX_W-1:0] pixel_in;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             last_of_item;
		logic             frame_done;
	} res_t;

	typedef struct packed {
		logic              issue;
		logic              clear;
		logic              use_ram;
		logic [TAP_W-1:0]  tap;
		logic [HSUM_W-1:0] imm;
	} mac_cmd_t;
endpackage

@@ design/gaussian_blur_5x5_separable_core.sv @@
// a result from a pixel beat goes through the horizontal issue and wait states, then the
// vertical ones; a result from a drain tick beat goes through the vertical ones only; at a row
// end the second and third results each take five more horizontal and five vertical steps on
// one shared multiplier, its pipeline drain and a line write; the core takes one beat at a time,
// and the next beat waits until the core is idle again, also while a result waits on res_ready
// the line buffer ram is not cleared; reset returns position, drain flag, pixel
// window and registers to their defaults, and the output register to empty
`timescale 1ns / 1ps
`include "gaussian_blur_5x5_separable_core_macros.svh"
module gaussian_blur_5x5_separable_core import gb5s_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [TAP_W-1:0] cfg_data
);
	typedef enum logic [2:0] {S_IDLE, S_H_ISSUE, S_H_WAIT, S_V_ISSUE, S_V_WAIT, S_WRITE}
		state_t;

	state_t            state_q;
	logic [2:0]        k_q;
	logic [1:0]        job_q, job_end_q;
	logic [PIX_W-1:0]  seq_q [7];
	logic [ROW_W-1:0]  r_q, o_q;
	logic [COL_W-1:0]  col_q;
	logic              has_cur_q, done_q;
	logic [HSUM_W-1:0] hv_q;
	logic [TAP_W-1:0]  taps_q [5];
	logic [ROW_W-1:0]  width_q, height_q;
	logic [PIX_W-1:0]  win_q [4];
	logic [COL_W-1:0]  col_pos_q;
	logic [ROW_W-1:0]  row_pos_q;
	logic              drain_q;
	res_t              res_q;
	logic              res_valid_q;

	logic [ROW_W-1:0]  w_eff, h_eff;
	logic              req_fire, cfg_fire, row_end, is_done, out_load;
	logic [PIX_W-1:0]  q0, q1, q2, q3;
	logic signed [ROW_W+1:0] rr_raw;
	logic [ROW_W-1:0]  rr;
	logic [2:0]        seq_idx;
	mac_cmd_t          cmd;
	logic [ACC_W-1:0]  acc;
	logic              mac_busy;
	logic [HSUM_W-1:0] rdata;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [ACC_W:0]    rounded;
	logic [ACC_W-2*TAP_FRAC_BITS:0] scaled;
	logic [PIX_W-1:0]  pix_sat;

	assign w_eff = (width_q < ROW_W'(3)) ? ROW_W'(3) :
		(width_q > ROW_W'(MAX_WIDTH)) ? ROW_W'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q < ROW_W'(3)) ? ROW_W'(3) : height_q;

	// a register write goes ahead of a waiting beat
	assign req_ready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign row_end = ROW_W'(col_pos_q) >= w_eff - ROW_W'(1);
	assign is_done = (row_pos_q >= h_eff - ROW_W'(1)) && row_end;

	// first column fills the window with the new pixel
	assign q0 = (col_pos_q == '0) ? req.pixel_in : win_q[0];
	assign q1 = (col_pos_q == '0) ? req.pixel_in : win_q[1];
	assign q2 = (col_pos_q == '0) ? req.pixel_in : win_q[2];
	assign q3 = (col_pos_q == '0) ? req.pixel_in : win_q[3];

	// vertical tap row, clamped to the frame
	assign rr_raw = $signed({2'b00, o_q}) + $signed({11'd0, k_q}) - 14'sd2;
	always_comb begin
		if (rr_raw < 0) begin
			rr = '0;
		end else if (rr_raw > $signed({2'b00, h_eff - ROW_W'(1)})) begin
			rr = h_eff - ROW_W'(1);
		end else begin
			rr = rr_raw[ROW_W-1:0];
		end
	end

	assign seq_idx = 3'(job_q) + k_q;

	always_comb begin
		cmd = '0;
		ram_re = 1'b0;
		case (state_q)
			S_H_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.clear = (k_q == '0);
				cmd.tap   = taps_q[k_q];
				cmd.imm   = HSUM_W'(seq_q[seq_idx]);
			end
			S_V_ISSUE: begin
				cmd.issue   = 1'b1;
				cmd.clear   = (k_q == '0);
				cmd.tap     = taps_q[k_q];
				cmd.imm     = hv_q;
				cmd.use_ram = !(has_cur_q && rr == r_q);
				ram_re      = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign ram_we   = (state_q == S_WRITE);
	assign ram_addr = ram_we ? {r_q[1:0], col_q} : {rr[1:0], col_q};

	gb5s_ram #(.WIDTH(HSUM_W), .DEPTH(RAM_DEPTH)) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (hv_q),
		.rdata (rdata)
	);

	gb5s_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rdata  (rdata),
		.acc    (acc),
		.busy   (mac_busy)
	);

	// round half up, drop fraction bits, saturate
	assign rounded = {1'b0, acc} + (ACC_W+1)'(64'd1 << (2*TAP_FRAC_BITS-1));
	assign scaled  = rounded[ACC_W:2*TAP_FRAC_BITS];
	assign pix_sat = (scaled > ($bits(scaled))'(255)) ? PIX_W'(255) : scaled[PIX_W-1:0];

	assign out_load = (state_q == S_V_WAIT) && !mac_busy && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			job_q       <= '0;
			job_end_q   <= '0;
			has_cur_q   <= 1'b0;
			done_q      <= 1'b0;
			width_q     <= ROW_W'(1920);
			height_q    <= ROW_W'(1080);
			taps_q[0]   <= TAP_W'(3571);
			taps_q[1]   <= TAP_W'(16004);
			taps_q[2]   <= TAP_W'(26386);
			taps_q[3]   <= TAP_W'(16004);
			taps_q[4]   <= TAP_W'(3571);
			for (int i = 0; i < 4; i++) begin
				win_q[i] <= '0;
			end
			col_pos_q   <= '0;
			row_pos_q   <= '0;
			drain_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && !out_load) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				case (cfg_index)
					REG_WIDTH, REG_HEIGHT: begin
						if (cfg_index == REG_WIDTH) begin
							width_q <= cfg_data[ROW_W-1:0];
						end else begin
							height_q <= cfg_data[ROW_W-1:0];
						end
						for (int i = 0; i < 4; i++) begin
							win_q[i] <= '0;
						end
						col_pos_q <= '0;
						row_pos_q <= '0;
						drain_q   <= 1'b0;
					end
					REG_TAP_M2: taps_q[0] <= cfg_data;
					REG_TAP_M1: taps_q[1] <= cfg_data;
					REG_TAP_C:  taps_q[2] <= cfg_data;
					REG_TAP_P1: taps_q[3] <= cfg_data;
					REG_TAP_P2: taps_q[4] <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire && req.req_type == REQ_DRAIN && drain_q) begin
						o_q       <= row_pos_q;
						col_q     <= col_pos_q;
						has_cur_q <= 1'b0;
						done_q    <= is_done;
						job_q     <= '0;
						job_end_q <= '0;
						k_q       <= '0;
						state_q   <= S_V_ISSUE;
						if (row_end) begin
							col_pos_q <= '0;
							if (is_done) begin
								row_pos_q <= '0;
								drain_q   <= 1'b0;
								for (int i = 0; i < 4; i++) begin
									win_q[i] <= '0;
								end
							end else begin
								row_pos_q <= row_pos_q + ROW_W'(1);
							end
						end else begin
							col_pos_q <= col_pos_q + COL_W'(1);
						end
					end else if (req_fire && req.req_type == REQ_PIXEL && !drain_q) begin
						seq_q[0]  <= q3;
						seq_q[1]  <= q2;
						seq_q[2]  <= q1;
						seq_q[3]  <= q0;
						seq_q[4]  <= req.pixel_in;
						seq_q[5]  <= req.pixel_in;
						seq_q[6]  <= req.pixel_in;
						r_q       <= row_pos_q;
						o_q       <= row_pos_q - ROW_W'(2);
						col_q     <= col_pos_q - COL_W'(2);
						has_cur_q <= 1'b1;
						done_q    <= 1'b0;
						job_q     <= '0;
						job_end_q <= row_end ? 2'd2 : 2'd0;
						k_q       <= '0;
						if (col_pos_q >= COL_W'(2)) begin
							state_q <= S_H_ISSUE;
						end
						win_q[3] <= q2;
						win_q[2] <= q1;
						win_q[1] <= q0;
						win_q[0] <= req.pixel_in;
						if (row_end) begin
							col_pos_q <= '0;
							if (row_pos_q >= h_eff - ROW_W'(1)) begin
								drain_q   <= 1'b1;
								row_pos_q <= h_eff - ROW_W'(2);
							end else begin
								row_pos_q <= row_pos_q + ROW_W'(1);
							end
						end else begin
							col_pos_q <= col_pos_q + COL_W'(1);
						end
					end
				end
				S_H_ISSUE: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						state_q <= S_H_WAIT;
					end
				end
				S_H_WAIT: begin
					if (!mac_busy) begin
						hv_q <= acc[HSUM_W-1:0];
						k_q  <= '0;
						state_q <= (r_q >= ROW_W'(2)) ? S_V_ISSUE : S_WRITE;
					end
				end
				S_V_ISSUE: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						state_q <= S_V_WAIT;
					end
				end
				S_V_WAIT: begin
					if (out_load) begin
						res_q.pixel_out    <= pix_sat;
						res_q.out_row      <= o_q;
						res_q.out_col      <= col_q;
						res_q.last_of_item <= (job_q == job_end_q);
						res_q.frame_done   <= done_q;
						res_valid_q        <= 1'b1;
						state_q <= has_cur_q ? S_WRITE : S_IDLE;
					end
				end
				S_WRITE: begin
					if (job_q == job_end_q) begin
						state_q <= S_IDLE;
					end else begin
						job_q   <= job_q + 2'd1;
						col_q   <= col_q + COL_W'(1);
						k_q     <= '0;
						state_q <= S_H_ISSUE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`GB5S_ASSERT_IMPL(a_write_quiet, ram_we, !mac_busy, "line write while mac busy")
	`GB5S_ASSERT_IMPL(a_done_last, res_valid && res.frame_done, res.last_of_item,
		"frame end not last of item")
	`GB5S_ASSERT_NEXT(a_load_valid, out_load, res_valid, "result load lost")
endmodule

@@ design/gb5s_ram.sv @@
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module gb5s_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

@@ design/gb5s_mac.sv @@
// shared multiply-accumulate pipeline for both filter passes
// depends on gb5s_pkg; operand comes from the command or from ram read data
`timescale 1ns / 1ps
module gb5s_mac import gb5s_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mac_cmd_t          cmd,
	input  logic [HSUM_W-1:0] rdata,
	output logic [ACC_W-1:0]  acc,
	output logic              busy
);
	logic              v_s1, v_s2;
	logic              use_ram_s1;
	logic [TAP_W-1:0]  tap_s1;
	logic [HSUM_W-1:0] imm_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [ACC_W-1:0]  acc_q;
	logic [HSUM_W-1:0] operand;

	assign operand = use_ram_s1 ? rdata : imm_s1;
	assign acc     = acc_q;
	assign busy    = v_s1 | v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		use_ram_s1 <= cmd.use_ram;
		tap_s1     <= cmd.tap;
		imm_s1     <= cmd.imm;
		prod_s2    <= PROD_W'(tap_s1) * PROD_W'(operand);
		if (cmd.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end
endmodule

@@ dv/tb.sv @@
// testbench for the separable 5x5 blur core: drives frames of pixels and drain ticks
// under random gaps and output stalls, predicts every result and checks it field by field
// depends on gb5s_pkg and gaussian_blur_5x5_separable_core
`timescale 1ns / 1ps
module tb;
	import gb5s_pkg::*;

	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	req_t             req;
	logic             res_valid;
	logic             res_ready;
	res_t             res;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [TAP_W-1:0] cfg_data;

	gaussian_blur_5x5_separable_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// blur state mirror
	bit [HSUM_W-1:0] line_buf [LINES][MAX_WIDTH];
	bit [PIX_W-1:0]  win [4];
	bit [TAP_W-1:0]  taps [5];
	int unsigned     img_w, img_h, col_p, row_p;
	bit              draining;

	res_t blur_q [$];
	int   errors, mismatches, items_sent, results_seen, frames_done, cycles;
	int   burst_left;
	bit   gaps_on, stall_on;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int unsigned eff_w();
		if (img_w < 3) return 3;
		if (img_w > MAX_WIDTH) return MAX_WIDTH;
		return img_w;
	endfunction

	function automatic int unsigned eff_h();
		return img_h < 3 ? 3 : img_h;
	endfunction

	function automatic bit [HSUM_W-1:0] row_sum(bit [7:0] a, bit [7:0] b, bit [7:0] c,
			bit [7:0] d, bit [7:0] e);
		longint unsigned s;
		s = taps[0] * a + taps[1] * b + taps[2] * c + taps[3] * d + taps[4] * e;
		return s[HSUM_W-1:0];
	endfunction

	function automatic bit [7:0] col_blur(int o, int col, int h, bit has_cur, int cur_row,
			bit [HSUM_W-1:0] cur);
		longint unsigned acc, v;
		int r;
		acc = 0;
		for (int k = 0; k < 5; k++) begin
			r = o + k - 2;
			if (r < 0) r = 0;
			if (r > h - 1) r = h - 1;
			v = (has_cur && r == cur_row) ? cur : line_buf[r & 3][col];
			acc += taps[k] * v;
		end
		acc = (acc + (64'd1 << (2 * TAP_FRAC_BITS - 1))) >> (2 * TAP_FRAC_BITS);
		return acc > 255 ? 8'd255 : acc[7:0];
	endfunction

	function automatic res_t make_res(bit [7:0] px, int r, int c, bit last, bit done);
		res_t x;
		x.pixel_out = px;
		x.out_row = r[ROW_W-1:0];
		x.out_col = c[COL_W-1:0];
		x.last_of_item = last;
		x.frame_done = done;
		return x;
	endfunction

	function automatic void restart_frame();
		foreach (win[i]) win[i] = '0;
		col_p = 0;
		row_p = 0;
		draining = 0;
	endfunction

	function automatic void column_finished(int r, int col, bit [HSUM_W-1:0] hv, int h,
			ref int n);
		if (r >= 2) begin
			blur_q.push_back(make_res(col_blur(r - 2, col, h, 1, r, hv), r - 2, col, 0, 0));
			n++;
		end
		line_buf[r & 3][col] = hv;
	endfunction

	function automatic void apply_cfg(bit [IDX_W-1:0] idx, bit [TAP_W-1:0] d);
		case (idx)
			REG_WIDTH: begin
				img_w = 32'(d[11:0]);
				restart_frame();
			end
			REG_HEIGHT: begin
				img_h = 32'(d[11:0]);
				restart_frame();
			end
			REG_TAP_M2, REG_TAP_M1, REG_TAP_C, REG_TAP_P1, REG_TAP_P2: begin
				taps[idx - REG_TAP_M2] = d;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void predict_blur(req_t it);
		int w, h, r, c, n;
		bit done;
		bit [7:0] p;
		w = eff_w();
		h = eff_h();
		p = it.pixel_in;
		n = 0;
		if (it.req_type == REQ_DRAIN) begin
			if (!draining) return;
			r = row_p;
			c = col_p;
			done = (r >= h - 1) && (c >= w - 1);
			blur_q.push_back(make_res(col_blur(r, c, h, 0, 0, '0), r, c, 1, done));
			if (c >= w - 1) begin
				if (done) restart_frame();
				else begin
					row_p = r + 1;
					col_p = 0;
				end
			end else begin
				col_p = c + 1;
			end
			return;
		end
		if (draining) return;
		r = row_p;
		c = col_p;
		if (c == 0) foreach (win[i]) win[i] = p;
		if (c >= 2) column_finished(r, c - 2, row_sum(win[3], win[2], win[1], win[0], p), h, n);
		if (c >= w - 1) begin
			column_finished(r, c - 1, row_sum(win[2], win[1], win[0], p, p), h, n);
			column_finished(r, c, row_sum(win[1], win[0], p, p, p), h, n);
			col_p = 0;
			if (r >= h - 1) begin
				draining = 1;
				row_p = h - 2;
			end else begin
				row_p = r + 1;
			end
		end else begin
			col_p = c + 1;
		end
		win[3] = win[2];
		win[2] = win[1];
		win[1] = win[0];
		win[0] = p;
		if (n > 0) blur_q[blur_q.size() - 1].last_of_item = 1'b1;
	endfunction

	// sender: called and returns at a falling edge
	task automatic send_item(logic kind, logic [7:0] px);
		if (gaps_on && burst_left == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		req.req_type = kind;
		req.pixel_in = px;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_blur(req);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req_valid = 1'b0;
		while (blur_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [TAP_W-1:0] d);
		wait_idle();
		cfg_index = idx;
		cfg_data = d;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_taps(int a, int b, int c, int d, int e);
		write_reg(REG_TAP_M2, a[15:0]);
		write_reg(REG_TAP_M1, b[15:0]);
		write_reg(REG_TAP_C, c[15:0]);
		write_reg(REG_TAP_P1, d[15:0]);
		write_reg(REG_TAP_P2, e[15:0]);
	endtask

	// one frame; noise adds ignored beats (early drain ticks, pixels during drain)
	task automatic send_frame(int w, int h, int pmode, bit noise);
		logic [7:0] px;
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				case (pmode)
					0: px = 8'($urandom_range(0, 255));
					1: px = ((r + c) & 1) ? 8'hff : 8'h00;
					default: px = 8'hff;
				endcase
				if (noise && $urandom_range(0, 15) == 0)
					send_item(REQ_DRAIN, 8'($urandom_range(0, 255)));
				send_item(REQ_PIXEL, px);
			end
		end
		for (int i = 0; i < 2 * w; i++) begin
			if (noise && $urandom_range(0, 9) == 0)
				send_item(REQ_PIXEL, 8'($urandom_range(0, 255)));
			send_item(REQ_DRAIN, 8'($urandom_range(0, 255)));
		end
		frames_done++;
	endtask

	task automatic test_small_extremes();
		write_reg(REG_WIDTH, 16'd3);
		write_reg(REG_HEIGHT, 16'd3);
		set_taps(3571, 16004, 26386, 16004, 3571);
		send_item(REQ_DRAIN, 8'h00);
		send_frame(3, 3, 1, 0);
		send_item(REQ_PIXEL, 8'hff);
		send_item(REQ_PIXEL, 8'h00);
		send_item(REQ_PIXEL, 8'h5a);
	endtask

	task automatic test_tap_extremes();
		write_reg(REG_WIDTH, 16'd0);
		write_reg(REG_HEIGHT, 16'd0);
		set_taps(65535, 65535, 65535, 65535, 65535);
		send_frame(3, 3, 2, 0);
		set_taps(0, 0, 0, 0, 0);
		send_frame(3, 3, 0, 0);
		write_reg(REG_NONE, 16'hffff);
	endtask

	// clamped width; only the start of the first row fits the item budget
	task automatic test_wide_frame();
		write_reg(REG_HEIGHT, 16'd4095);
		set_taps(3571, 16004, 26386, 16004, 3571);
		write_reg(REG_WIDTH, 16'd4095);
		write_reg(REG_HEIGHT, 16'd3);
		stall_on = 0;
		for (int i = 0; i < 24; i++) send_item(REQ_PIXEL, 8'($urandom_range(0, 255)));
		stall_on = 1;
	endtask

	task automatic test_random_frames();
		int w, h, start;
		start = items_sent;
		while (items_sent - start < 280) begin
			w = $urandom_range(0, 3) == 0 ? $urandom_range(3, 12) : $urandom_range(3, 6);
			h = $urandom_range(3, 6);
			write_reg(REG_WIDTH, w[15:0]);
			write_reg(REG_HEIGHT, h[15:0]);
			if ($urandom_range(0, 1)) set_taps($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
			else write_reg(REG_TAP_C, 16'($urandom_range(0, 65535)));
			gaps_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 5) == 0) begin
				// frame cut short, then restarted by the geometry write
				for (int i = $urandom_range(1, w * h); i > 0; i--)
					send_item($urandom_range(0, 4) == 0, 8'($urandom_range(0, 255)));
			end else begin
				send_frame(w, h, 0, $urandom_range(0, 2) == 0);
			end
		end
		gaps_on = 1;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (blur_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected beat %p", res);
			end else begin
				res_t e;
				e = blur_q.pop_front();
				if (res.pixel_out !== e.pixel_out || res.out_row !== e.out_row ||
						res.out_col !== e.out_col || res.last_of_item !== e.last_of_item ||
						res.frame_done !== e.frame_done) begin
					errors++;
					if (mismatches++ < 10) $display("mismatch exp %p got %p", e, res);
				end
			end
		end
	end

	always @(negedge clk) begin
		res_ready <= stall_on ? (((cycles >> 8) & 1) ? ($urandom_range(0, 2) != 0) :
			((cycles % 7) != 3)) : 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gaps_on = 1;
		stall_on = 1;
		burst_left = 0;
		img_w = 1920;
		img_h = 1080;
		taps = '{3571, 16004, 26386, 16004, 3571};
		restart_frame();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_small_extremes();
		test_tap_extremes();
		test_random_frames();
		test_wide_frame();
		wait_idle();
		repeat (60) @(negedge clk);
		$display("ran %0d items (%0d full frames), checked %0d blurred pixels",
			items_sent, frames_done, results_seen);
		if (errors == 0 && blur_q.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("%0d failures, %0d results missing", errors, blur_q.size());
			$display("tb: errors");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+design
design/gb5s_pkg.sv
design/gb5s_ram.sv
design/gb5s_mac.sv
design/gaussian_blur_5x5_separable_core.sv
dv/tb.sv
